@@ src/kmm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kmm_pkg: shared definitions for the keyed min/max priority table
// Sizes, operation and status codes, cell commands and the types that
// travel between the top level, the cell chain and the cells.
// ----------------------------------------------------------------------------
package kmm_pkg;

    // table sizes
    localparam int ENTRIES     = 256;
    localparam int ID_WIDTH    = 16;
    localparam int LEVEL_WIDTH = 8;
    localparam int KEY_WIDTH   = LEVEL_WIDTH + ID_WIDTH;
    localparam int CNT_WIDTH   = $clog2(ENTRIES + 1);

    localparam logic [CNT_WIDTH-1:0] FULL_COUNT = CNT_WIDTH'(ENTRIES);

    // operation codes
    localparam logic [1:0] FN_ADD    = 2'd0;
    localparam logic [1:0] FN_REMOVE = 2'd1;
    localparam logic [1:0] FN_HIGH   = 2'd2;
    localparam logic [1:0] FN_LOW    = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // commands broadcast to every cell
    localparam logic [1:0] CMD_IDLE   = 2'd0;
    localparam logic [1:0] CMD_MATCH  = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_INSERT = 2'd3;

    // sort key: level in the upper bits, id in the lower bits
    typedef logic [KEY_WIDTH-1:0] key_t;

    typedef struct packed {
        logic [1:0] cmd;
        key_t       key;
    } cell_ctrl_t;

    // contents of one cell
    typedef struct packed {
        logic valid;
        key_t key;
    } slot_t;

    // what a cell hands to the next cell up the chain
    typedef struct packed {
        logic valid;
        key_t key;
        logic lt;
    } up_link_t;

endpackage
`default_nettype wire

@@ src/kmm_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kmm_in_if / kmm_out_if: item channels of the priority table
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface kmm_in_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     func;
    logic [kmm_pkg::ID_WIDTH-1:0]   item_id;
    logic [kmm_pkg::LEVEL_WIDTH-1:0] item_level;

    modport source (output valid, output func, output item_id, output item_level,
                    input ready);
    modport sink   (input valid, input func, input item_id, input item_level,
                    output ready);
endinterface

interface kmm_out_if;
    logic                         valid;
    logic                         ready;
    logic [kmm_pkg::ID_WIDTH-1:0] result_id;
    logic [1:0]                   status;

    modport source (output valid, output result_id, output status, input ready);
    modport sink   (input valid, input result_id, input status, output ready);
endinterface
`default_nettype wire

@@ src/kmm_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kmm_cell: one cell of the sorted chain
// Holds one key, matches it against a broadcast id, shifts down on a
// remove and up on an insert, trading data with both neighbors.
// ----------------------------------------------------------------------------
module kmm_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire kmm_pkg::cell_ctrl_t ctrl,
    input  wire kmm_pkg::up_link_t   below,
    input  wire kmm_pkg::slot_t      above,
    input  wire logic                shift,
    output kmm_pkg::up_link_t        up,
    output kmm_pkg::slot_t           down,
    output logic                     hit
);
    import kmm_pkg::*;

    logic valid_reg, valid_next;
    key_t key_reg, key_next;
    logic hit_reg, hit_next;
    logic lt;

    // new key sorts below this cell; an empty cell counts as the top
    assign lt = !valid_reg || (ctrl.key < key_reg);

    // next contents
    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        hit_next   = hit_reg;
        unique case (ctrl.cmd)
            CMD_MATCH:
            begin
                hit_next = valid_reg && (key_reg[ID_WIDTH-1:0] == ctrl.key[ID_WIDTH-1:0]);
            end
            CMD_REMOVE:
            begin
                if (shift)
                begin
                    valid_next = above.valid;
                    key_next   = above.key;
                end
            end
            CMD_INSERT:
            begin
                if (lt)
                begin
                    if (below.lt)
                    begin
                        valid_next = below.valid;
                        key_next   = below.key;
                    end
                    else
                    begin
                        valid_next = 1'b1;
                        key_next   = ctrl.key;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // control bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
        end
    end

    // key payload
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    // neighbor links
    assign up.valid   = valid_reg;
    assign up.key     = key_reg;
    assign up.lt      = lt;
    assign down.valid = valid_reg;
    assign down.key   = key_reg;
    assign hit        = hit_reg;

endmodule
`default_nettype wire

@@ src/kmm_chain.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kmm_chain: row of cells kept sorted by ascending key
// Valid entries fill the low cells with the smallest key in cell zero.
// A prefix of the match flags tells every cell at or above a hit to shift.
// ----------------------------------------------------------------------------
module kmm_chain (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire kmm_pkg::cell_ctrl_t ctrl,
    output kmm_pkg::slot_t           head,
    output logic                     any_hit
);
    import kmm_pkg::*;

    up_link_t             up_link   [ENTRIES];
    slot_t                down_link [ENTRIES];
    logic [ENTRIES-1:0]   hit_vec;
    logic [ENTRIES-1:0]   shift_vec;

    // cell row
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        up_link_t below;
        slot_t    above;

        if (i == 0)
        begin : g_bottom
            assign below = '0;
        end
        else
        begin : g_inner_below
            assign below = up_link[i-1];
        end

        if (i == ENTRIES - 1)
        begin : g_top
            assign above = '0;
        end
        else
        begin : g_inner_above
            assign above = down_link[i+1];
        end

        kmm_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .below (below),
            .above (above),
            .shift (shift_vec[i]),
            .up    (up_link[i]),
            .down  (down_link[i]),
            .hit   (hit_vec[i])
        );
    end

    // hit at or below each cell, log-depth prefix or
    always_comb
    begin
        shift_vec = hit_vec;
        for (int d = 1; d < ENTRIES; d = d * 2)
        begin
            shift_vec = shift_vec | (shift_vec << d);
        end
    end

    assign any_hit = shift_vec[ENTRIES-1];
    assign head    = down_link[0];

endmodule
`default_nettype wire

@@ src/keyed_min_max_priority_table.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_min_max_priority_table: id-to-level table with min and max query
// Two sorted cell chains answer highest and lowest from their bottom cell.
// ----------------------------------------------------------------------------
// Each item gets exactly one result. A query goes from accept straight to
// the result stage. A remove or an add has the cells match the id, then
// a shift that takes it out or puts a new key in, then a second shift when
// an update of an id already present moves it to its new place, and last
// the load of the result register, which waits until the output is free.
// The chains are kept sorted by (level, id); one holds the keys as they
// are, the other holds them inverted, so the lowest and the highest entry
// always sit in cell zero and a query reads them directly.
// A new item is taken while an earlier result still waits at the output.
module keyed_min_max_priority_table (
    input  wire logic  clk,
    input  wire logic  rst_n,
    kmm_in_if.sink     in_ch,
    kmm_out_if.source  out_ch
);
    import kmm_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MATCH  = 3'd1;
    localparam logic [2:0] S_APPLY  = 3'd2;
    localparam logic [2:0] S_INSERT = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [1:0]             func_reg;
    logic [ID_WIDTH-1:0]    id_reg;
    logic [LEVEL_WIDTH-1:0] level_reg;
    logic                   full_reg, full_next;
    logic [CNT_WIDTH-1:0]   count_reg, count_next;
    logic                   out_valid_reg, out_valid_next;
    logic [ID_WIDTH-1:0]    result_id_reg;
    logic [1:0]             status_reg;

    cell_ctrl_t             ctrl_a, ctrl_b;
    slot_t                  head_a, head_b;
    logic                   any_hit_a, any_hit_b;
    logic [1:0]             cmd;
    logic                   accept, out_free, is_add, is_query;
    logic [ID_WIDTH-1:0]    res_id;
    logic [1:0]             res_status;

    assign accept   = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;
    assign is_add   = (func_reg == FN_ADD);
    assign is_query = (func_reg == FN_HIGH) || (func_reg == FN_LOW);

    // sequencer and entry count
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        full_next  = full_reg;
        cmd        = CMD_IDLE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    full_next = 1'b0;
                    if ((in_ch.func == FN_HIGH) || (in_ch.func == FN_LOW))
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_MATCH;
                    end
                end
            end
            S_MATCH:
            begin
                cmd        = CMD_MATCH;
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                state_next = S_FINISH;
                if (any_hit_a)
                begin
                    // take the id out; an update puts it back next cycle
                    cmd = CMD_REMOVE;
                    if (is_add)
                    begin
                        state_next = S_INSERT;
                    end
                    else
                    begin
                        count_next = count_reg - CNT_WIDTH'(1);
                    end
                end
                else if (is_add)
                begin
                    if (count_reg == FULL_COUNT)
                    begin
                        full_next = 1'b1;
                    end
                    else
                    begin
                        cmd        = CMD_INSERT;
                        count_next = count_reg + CNT_WIDTH'(1);
                    end
                end
            end
            S_INSERT:
            begin
                cmd        = CMD_INSERT;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // cell commands, inverted keys for the max chain
    assign ctrl_a.cmd = cmd;
    assign ctrl_a.key = {level_reg, id_reg};
    assign ctrl_b.cmd = cmd;
    assign ctrl_b.key = ~{level_reg, id_reg};

    kmm_chain u_chain_min (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl_a),
        .head    (head_a),
        .any_hit (any_hit_a)
    );

    kmm_chain u_chain_max (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl_b),
        .head    (head_b),
        .any_hit (any_hit_b)
    );

    // result of the finished item
    always_comb
    begin
        res_id     = '0;
        res_status = ST_OK;
        if (is_query)
        begin
            if (count_reg == '0)
            begin
                res_status = ST_EMPTY;
            end
            else if (func_reg == FN_HIGH)
            begin
                res_id = ~head_b.key[ID_WIDTH-1:0];
            end
            else
            begin
                res_id = head_a.key[ID_WIDTH-1:0];
            end
        end
        else if (full_reg)
        begin
            res_status = ST_FULL;
        end
    end

    // output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        if ((state_reg == S_FINISH) && out_free)
        begin
            out_valid_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            full_reg      <= full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= in_ch.func;
            id_reg    <= in_ch.item_id;
            level_reg <= in_ch.item_level;
        end
        if ((state_reg == S_FINISH) && out_free)
        begin
            result_id_reg <= res_id;
            status_reg    <= res_status;
        end
    end

    assign in_ch.ready      = (state_reg == S_IDLE);
    assign out_ch.valid     = out_valid_reg;
    assign out_ch.result_id = result_id_reg;
    assign out_ch.status    = status_reg;

    // both chains hold the same set of ids
    a_hit_agree: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY) |-> (any_hit_a == any_hit_b))
        else $error("min and max chains disagree on id match");

    // bottom cells are filled exactly when the table holds entries,
    // except while an updated id is out of the chains
    a_head_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_INSERT) |->
            ((head_a.valid == (count_reg != '0)) && (head_b.valid == (count_reg != '0))))
        else $error("chain head does not agree with entry count");

    // count never passes capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count above capacity");

    // a query goes straight to the result stage
    a_query_path: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && ((in_ch.func == FN_HIGH) || (in_ch.func == FN_LOW)))
            |=> (state_reg == S_FINISH))
        else $error("query did not go straight to the result stage");

    // a dropped add leaves the count unchanged
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY && full_next) |=> $stable(count_reg))
        else $error("count changed on a dropped add");

endmodule
`default_nettype wire

@@ tb/tb_keyed_min_max_priority_table.sv @@
// ----------------------------------------------------------------------------
// tb_keyed_min_max_priority_table: self-checking bench for the priority table
// Drives add, remove and query items over the input channel and keeps its
// own copy of the id-to-level table to work out each expected result. The
// results that come back are compared in order against that copy. Both
// channel ends idle at random, and the output end also holds off for long
// stretches so that the block has to stall its input.
// ----------------------------------------------------------------------------
module tb_keyed_min_max_priority_table;

    timeunit 1ns;
    timeprecision 1ps;

    import kmm_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int SETTLE_TICKS = 16;
    localparam int RANDOM_ITEMS = 1550;
    localparam int IDLE_PCT     = 22;

    // expected result of one item
    typedef struct packed {
        logic [1:0]          op;
        logic [ID_WIDTH-1:0] result_id;
        logic [1:0]          status;
    } table_answer_t;

    logic clk;
    logic rst_n;

    kmm_in_if  in_ch ();
    kmm_out_if out_ch ();

    keyed_min_max_priority_table i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // mirror of the table contents
    logic                   tbl_used [ENTRIES];
    logic [ID_WIDTH-1:0]    tbl_id   [ENTRIES];
    logic [LEVEL_WIDTH-1:0] tbl_lvl  [ENTRIES];
    int                     tbl_count;

    table_answer_t answers_due [$];
    int            errors;
    int            cycle_count;
    int            out_hold;
    bit            no_idle;

    // clock
    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // apply one item to the mirror and return the result it should give
    function automatic table_answer_t apply_op(input logic [1:0] op,
                                               input logic [ID_WIDTH-1:0] id,
                                               input logic [LEVEL_WIDTH-1:0] lv);
        table_answer_t          ans;
        int                     hit;
        int                     open_slot;
        int                     i;
        logic                   found;
        logic [KEY_WIDTH-1:0]   best;
        logic [KEY_WIDTH-1:0]   cand;
        ans.op        = op;
        ans.result_id = '0;
        ans.status    = ST_OK;
        hit           = -1;
        open_slot     = -1;
        for (i = 0; i < ENTRIES; i++)
        begin
            if (tbl_used[i] && tbl_id[i] == id)
                hit = i;
            if (!tbl_used[i] && open_slot < 0)
                open_slot = i;
        end
        case (op)
            FN_ADD:
            begin
                if (hit >= 0)
                    tbl_lvl[hit] = lv;
                else if (open_slot < 0)
                    ans.status = ST_FULL;
                else
                begin
                    tbl_used[open_slot] = 1'b1;
                    tbl_id[open_slot]   = id;
                    tbl_lvl[open_slot]  = lv;
                    tbl_count++;
                end
            end
            FN_REMOVE:
            begin
                if (hit >= 0)
                begin
                    tbl_used[hit] = 1'b0;
                    tbl_count--;
                end
            end
            default:
            begin
                // ids are unique, so ordering by {level, id} settles ties
                found = 1'b0;
                best  = '0;
                for (i = 0; i < ENTRIES; i++)
                begin
                    if (tbl_used[i])
                    begin
                        cand = {tbl_lvl[i], tbl_id[i]};
                        if (!found || (op == FN_HIGH ? cand > best : cand < best))
                        begin
                            best  = cand;
                            found = 1'b1;
                        end
                    end
                end
                if (found)
                    ans.result_id = best[ID_WIDTH-1:0];
                else
                    ans.status = ST_EMPTY;
            end
        endcase
        return ans;
    endfunction

    function automatic bit id_stored(input logic [ID_WIDTH-1:0] id);
        int i;
        for (i = 0; i < ENTRIES; i++)
            if (tbl_used[i] && tbl_id[i] == id)
                return 1'b1;
        return 1'b0;
    endfunction

    // random slot among the stored entries; table must not be empty
    function automatic int pick_live_slot();
        int k;
        int i;
        k = $urandom_range(tbl_count - 1);
        for (i = 0; i < ENTRIES; i++)
        begin
            if (tbl_used[i])
            begin
                if (k == 0)
                    return i;
                k--;
            end
        end
        return 0;
    endfunction

    function automatic logic [ID_WIDTH-1:0] fresh_id();
        logic [ID_WIDTH-1:0] id;
        id = ID_WIDTH'($urandom);
        while (id_stored(id))
            id = ID_WIDTH'($urandom);
        return id;
    endfunction

    // an id for add or remove: a stored one with the given odds, else any
    function automatic logic [ID_WIDTH-1:0] pick_id(input int live_pct);
        if (tbl_count > 0 && $urandom_range(99) < live_pct)
            return tbl_id[pick_live_slot()];
        return ID_WIDTH'($urandom);
    endfunction

    // levels lean toward the extremes and toward levels already stored
    function automatic logic [LEVEL_WIDTH-1:0] pick_level();
        case ($urandom_range(3))
            0:       return $urandom_range(1) ? '1 : '0;
            1:       return tbl_count > 0 ? tbl_lvl[pick_live_slot()]
                                          : LEVEL_WIDTH'($urandom);
            default: return LEVEL_WIDTH'($urandom);
        endcase
    endfunction

    // offer one item, wait for it to be taken, record what it should return
    task automatic send_op(input logic [1:0] op,
                           input logic [ID_WIDTH-1:0] id,
                           input logic [LEVEL_WIDTH-1:0] lv);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.func       <= op;
        in_ch.item_id    <= id;
        in_ch.item_level <= lv;
        do
            @(posedge clk);
        while (!in_ch.ready);
        answers_due.push_back(apply_op(op, id, lv));
    endtask

    task automatic send_query(input logic [1:0] op);
        send_op(op, ID_WIDTH'($urandom), LEVEL_WIDTH'($urandom));
    endtask

    // stop offering items until every result is back
    task automatic settle_results();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (answers_due.size() != 0);
    endtask

    // extremes, ties in both directions, updates, absent removes, empty queries
    task automatic test_directed();
        send_query(FN_HIGH);
        send_query(FN_LOW);
        send_op(FN_REMOVE, 16'h1234, 8'h5a);
        send_op(FN_ADD,    16'h0000, 8'h00);
        send_op(FN_ADD,    16'hffff, 8'hff);
        send_query(FN_HIGH);
        send_query(FN_LOW);
        send_op(FN_ADD,    16'h5555, 8'haa);
        send_op(FN_ADD,    16'haaaa, 8'haa);
        send_op(FN_ADD,    16'hffff, 8'h00);
        send_query(FN_LOW);
        send_query(FN_HIGH);
        send_op(FN_ADD,    16'h0000, 8'haa);
        send_query(FN_HIGH);
        send_query(FN_LOW);
        send_op(FN_REMOVE, 16'haaaa, 8'h33);
        send_query(FN_HIGH);
        send_op(FN_REMOVE, 16'h5555, 8'hcc);
        send_op(FN_REMOVE, 16'h5555, 8'h00);
        send_op(FN_REMOVE, 16'h0000, 8'hff);
        send_query(FN_LOW);
        send_op(FN_REMOVE, 16'hffff, 8'h01);
        send_query(FN_HIGH);
        settle_results();
    endtask

    // fill to capacity, then new adds are dropped while updates still land
    task automatic test_full_table();
        while (tbl_count < ENTRIES)
            send_op(FN_ADD, fresh_id(), pick_level());
        send_op(FN_ADD, fresh_id(), pick_level());
        send_op(FN_ADD, tbl_id[pick_live_slot()], pick_level());
        send_query(FN_HIGH);
        send_query(FN_LOW);
        send_op(FN_REMOVE, tbl_id[pick_live_slot()], LEVEL_WIDTH'($urandom));
        send_op(FN_ADD, fresh_id(), pick_level());
        send_op(FN_ADD, fresh_id(), pick_level());
        send_query(FN_HIGH);
        settle_results();
    endtask

    // output held off while the input keeps offering items
    task automatic test_backpressure();
        int n;
        no_idle  = 1'b1;
        out_hold = 150;
        for (n = 0; n < 40; n++)
        begin
            case ($urandom_range(3))
                0:       send_op(FN_ADD, pick_id(70), pick_level());
                1:       send_op(FN_REMOVE, pick_id(50), LEVEL_WIDTH'($urandom));
                2:       send_query(FN_HIGH);
                default: send_query(FN_LOW);
            endcase
        end
        settle_results();
        no_idle = 1'b0;
    endtask

    // random traffic swinging the table between empty and full
    task automatic test_random();
        int  n;
        int  r;
        bit  filling;
        filling = 1'b0;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            // long stretch at full rate on both sides
            no_idle = (n < 300);
            r = $urandom_range(99);
            if (filling)
            begin
                if (r < 60)
                    send_op(FN_ADD, pick_id(40), pick_level());
                else if (r < 70)
                    send_op(FN_REMOVE, pick_id(60), LEVEL_WIDTH'($urandom));
                else
                    send_query($urandom_range(1) ? FN_HIGH : FN_LOW);
            end
            else
            begin
                if (r < 15)
                    send_op(FN_ADD, pick_id(50), pick_level());
                else if (r < 70)
                    send_op(FN_REMOVE, pick_id(80), LEVEL_WIDTH'($urandom));
                else
                    send_query($urandom_range(1) ? FN_HIGH : FN_LOW);
            end
            // turn around after lingering a little at either end
            if ((filling && tbl_count == ENTRIES) || (!filling && tbl_count == 0))
            begin
                if ($urandom_range(15) == 0)
                begin
                    filling = !filling;
                    settle_results();
                end
            end
        end
        no_idle = 1'b0;
    endtask

    // output ready: random idling, plus long hold-offs on request
    always @(posedge clk)
    begin
        if (out_hold > 0)
        begin
            out_ch.ready <= 1'b0;
            out_hold--;
        end
        else
            out_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    // compare each result with the oldest expectation
    always @(posedge clk)
    begin
        table_answer_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (answers_due.size() == 0)
            begin
                $display("%0t: unexpected result, actual id %h status %0d",
                         $time, out_ch.result_id, out_ch.status);
                errors++;
            end
            else
            begin
                want = answers_due.pop_front();
                if (out_ch.result_id !== want.result_id)
                begin
                    $display("%0t: func %0d result_id mismatch, expected %h actual %h",
                             $time, want.op, want.result_id, out_ch.result_id);
                    errors++;
                end
                if (out_ch.status !== want.status)
                begin
                    $display("%0t: func %0d status mismatch, expected %0d actual %0d",
                             $time, want.op, want.status, out_ch.status);
                    errors++;
                end
            end
        end
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // reset, tests in turn, then drain and report
    initial
    begin
        int i;
        errors           = 0;
        out_hold         = 0;
        no_idle          = 1'b0;
        tbl_count        = 0;
        for (i = 0; i < ENTRIES; i++)
        begin
            tbl_used[i] = 1'b0;
            tbl_id[i]   = '0;
            tbl_lvl[i]  = '0;
        end
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.func       = FN_ADD;
        in_ch.item_id    = '0;
        in_ch.item_level = '0;
        out_ch.ready     = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_table();
        test_backpressure();
        test_random();

        settle_results();
        repeat (SETTLE_TICKS) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
